// ===== design/nor_erase_pkg.sv =====
// shared types, command words and outcome codes of the spi nor erase sequencer
`timescale 1ns / 1ps
`default_nettype none
package nor_erase_pkg;

	// geometry defaults
	localparam int SUBSECTOR_MASK_BITS_DEFAULT = 12;
	localparam int SECTOR_MASK_BITS_DEFAULT    = 16;
	localparam int JOB_FIFO_DEPTH_DEFAULT      = 4;

	// register reset
	localparam logic [18:0] POLL_LIMIT_RESET = 19'd300000;

	// packed core command words
	localparam logic [31:0] WORD_WREN      = 32'h0600_0000;
	localparam logic [31:0] WORD_BULK      = 32'hC700_0000;
	localparam logic [31:0] WORD_SECTOR    = 32'hD800_0004;
	localparam logic [31:0] WORD_SUBSECTOR = 32'h2000_0004;
	localparam logic [31:0] WORD_STATUS    = 32'h0504_0000;

	// result outcome codes
	typedef enum logic [1:0] {
		OUTCOME_BUSY    = 2'd0,
		OUTCOME_DONE    = 2'd1,
		OUTCOME_INVALID = 2'd2,
		OUTCOME_TIMEOUT = 2'd3
	} outcome_t;

	// input item kinds
	typedef enum logic {
		KIND_START  = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	// work handed from front to back
	typedef enum logic [1:0] {
		JOB_STEP,
		JOB_POLL,
		JOB_END
	} job_op_t;

	typedef enum logic [1:0] {
		ERASE_BULK,
		ERASE_SECTOR,
		ERASE_SUBSECTOR
	} erase_t;

	typedef struct packed {
		job_op_t     op;
		erase_t      erase;
		logic [31:0] address;
		outcome_t    outcome;
	} job_t;

	// push side of the job queue
	typedef struct packed {
		logic push;
		job_t job;
	} job_push_t;

endpackage
`default_nettype wire

// ===== design/nor_erase_fifo.sv =====
// small register queue of jobs between front and back
`timescale 1ns / 1ps
`default_nettype none
module nor_erase_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// queue never overruns or underruns
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full && !pop))
		else $error("job queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("job queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("job queue count beyond depth");

endmodule
`default_nettype wire

// ===== design/nor_erase_front.sv =====
// front: accepts items, keeps erase state and plans the next job
`timescale 1ns / 1ps
`default_nettype none
module nor_erase_front
	import nor_erase_pkg::*;
#(
	parameter int SUBSECTOR_MASK_BITS = SUBSECTOR_MASK_BITS_DEFAULT,
	parameter int SECTOR_MASK_BITS    = SECTOR_MASK_BITS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        in_kind,
	input  wire logic [31:0] in_address,
	input  wire logic [31:0] in_length,
	input  wire logic [7:0]  in_status,
	input  wire logic        cfg_write,
	input  wire logic [18:0] cfg_value,
	input  wire logic        queue_full,
	output job_push_t        queue_in
);

	localparam logic [31:0] SUB_MASK = 32'((64'd1 << SUBSECTOR_MASK_BITS) - 64'd1);
	localparam logic [31:0] SEC_MASK = 32'((64'd1 << SECTOR_MASK_BITS) - 64'd1);
	localparam logic [31:0] SUB_SIZE = 32'(64'd1 << SUBSECTOR_MASK_BITS);
	localparam logic [31:0] SEC_SIZE = 32'(64'd1 << SECTOR_MASK_BITS);

	logic [18:0] poll_limit_q;
	logic        phase_q;
	logic [31:0] address_q;
	logic [31:0] length_q;
	logic [18:0] busy_polls_q;

	logic        phase_n;
	logic [31:0] address_n;
	logic [31:0] length_n;
	logic [18:0] busy_polls_n;
	logic [18:0] busy_inc;
	logic        accept;
	logic        do_plan;
	logic [31:0] plan_addr;
	logic [31:0] plan_len;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign busy_inc = busy_polls_q + 1'b1;

	// classify the item and plan the step
	always_comb begin
		phase_n        = phase_q;
		address_n      = address_q;
		length_n       = length_q;
		busy_polls_n   = busy_polls_q;
		do_plan        = 1'b0;
		plan_addr      = address_q;
		plan_len       = length_q;
		queue_in.push  = 1'b0;
		queue_in.job   = '{op: JOB_END, erase: ERASE_BULK, address: '0,
			outcome: OUTCOME_BUSY};
		if (accept) begin
			if (kind_t'(in_kind) == KIND_START) begin
				if (in_length <= SUB_MASK) begin
					// too short to erase anything
					address_n            = '0;
					length_n             = '0;
					phase_n              = 1'b0;
					busy_polls_n         = '0;
					queue_in.push        = 1'b1;
					queue_in.job.outcome = OUTCOME_INVALID;
				end else begin
					do_plan   = 1'b1;
					plan_addr = in_address;
					plan_len  = in_length;
				end
			end else if (phase_q) begin
				if (!in_status[0]) begin
					if (length_q == '0) begin
						phase_n              = 1'b0;
						busy_polls_n         = '0;
						queue_in.push        = 1'b1;
						queue_in.job.outcome = OUTCOME_DONE;
					end else begin
						do_plan = 1'b1;
					end
				end else if (busy_inc >= poll_limit_q) begin
					phase_n              = 1'b0;
					busy_polls_n         = '0;
					queue_in.push        = 1'b1;
					queue_in.job.outcome = OUTCOME_TIMEOUT;
				end else begin
					busy_polls_n    = busy_inc;
					queue_in.push   = 1'b1;
					queue_in.job.op = JOB_POLL;
				end
			end
		end

		// next erase step from address alignment and remaining length
		if (do_plan) begin
			queue_in.push        = 1'b1;
			queue_in.job.op      = JOB_STEP;
			queue_in.job.address = plan_addr;
			phase_n              = 1'b1;
			busy_polls_n         = '0;
			address_n            = plan_addr;
			length_n             = plan_len;
			priority if (plan_addr == '0 && plan_len == '1) begin
				queue_in.job.erase = ERASE_BULK;
				length_n           = '0;
			end else if ((plan_addr & SEC_MASK) == '0 && plan_len > SEC_MASK) begin
				queue_in.job.erase = ERASE_SECTOR;
				address_n          = plan_addr + SEC_SIZE;
				length_n           = plan_len - SEC_SIZE;
			end else if ((plan_addr & SUB_MASK) == '0 && plan_len > SUB_MASK) begin
				queue_in.job.erase = ERASE_SUBSECTOR;
				address_n          = plan_addr + SUB_SIZE;
				length_n           = plan_len - SUB_SIZE;
			end else begin
				queue_in.job.op      = JOB_END;
				queue_in.job.outcome = OUTCOME_INVALID;
				phase_n              = 1'b0;
			end
		end
	end

	// erase state and poll limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RESET;
			phase_q      <= 1'b0;
			address_q    <= '0;
			length_q     <= '0;
			busy_polls_q <= '0;
		end else begin
			if (cfg_write) begin
				poll_limit_q <= cfg_value;
			end
			phase_q      <= phase_n;
			address_q    <= address_n;
			length_q     <= length_n;
			busy_polls_q <= busy_polls_n;
		end
	end

endmodule
`default_nettype wire

// ===== design/nor_erase_back.sv =====
// back: turns queued jobs into command words, one word per cycle while out_ready holds
`timescale 1ns / 1ps
`default_nettype none
module nor_erase_back
	import nor_erase_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire job_t        head,
	input  wire logic        queue_empty,
	output logic             queue_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      out_word,
	output logic [31:0]      out_address,
	output logic             out_has_address,
	output logic [1:0]       out_outcome,
	output logic             out_last
);

	localparam logic [1:0] BEAT_WREN   = 2'd0;
	localparam logic [1:0] BEAT_ERASE  = 2'd1;
	localparam logic [1:0] BEAT_STATUS = 2'd2;

	logic        out_valid_q;
	logic [31:0] word_q;
	logic [31:0] address_q;
	logic        has_address_q;
	logic [1:0]  outcome_q;
	logic        last_q;
	logic [1:0]  beat_q;

	logic        load;
	logic        take;
	logic        job_last;
	logic [31:0] beat_word;
	logic [31:0] beat_address;
	logic        beat_has_address;

	assign load      = !out_valid_q || out_ready;
	assign take      = load && !queue_empty;
	assign job_last  = (head.op != JOB_STEP) || (beat_q == BEAT_STATUS);
	assign queue_pop = take && job_last;

	assign out_valid       = out_valid_q;
	assign out_word        = word_q;
	assign out_address     = address_q;
	assign out_has_address = has_address_q;
	assign out_outcome     = outcome_q;
	assign out_last        = last_q;

	// word for the current beat of the head job
	always_comb begin
		beat_word        = '0;
		beat_address     = '0;
		beat_has_address = 1'b0;
		unique case (head.op)
			JOB_STEP: begin
				unique case (beat_q)
					BEAT_WREN: beat_word = WORD_WREN;
					BEAT_ERASE: begin
						unique case (head.erase)
							ERASE_SECTOR: begin
								beat_word        = WORD_SECTOR;
								beat_address     = head.address;
								beat_has_address = 1'b1;
							end
							ERASE_SUBSECTOR: begin
								beat_word        = WORD_SUBSECTOR;
								beat_address     = head.address;
								beat_has_address = 1'b1;
							end
							default: beat_word = WORD_BULK;
						endcase
					end
					default: beat_word = WORD_STATUS;
				endcase
			end
			JOB_POLL: beat_word = WORD_STATUS;
			default:  beat_word = '0;
		endcase
	end

	// output register and beat counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			beat_q        <= BEAT_WREN;
			word_q        <= '0;
			address_q     <= '0;
			has_address_q <= 1'b0;
			outcome_q     <= OUTCOME_BUSY;
			last_q        <= 1'b0;
		end else if (load) begin
			out_valid_q <= !queue_empty;
			if (take) begin
				word_q        <= beat_word;
				address_q     <= beat_address;
				has_address_q <= beat_has_address;
				outcome_q     <= (head.op == JOB_END) ? head.outcome : OUTCOME_BUSY;
				last_q        <= job_last;
				beat_q        <= job_last ? BEAT_WREN : beat_q + 1'b1;
			end
		end
	end

	// beat counter stays within a step and only walks step jobs
	assert property (@(posedge clk) disable iff (!arst_n) beat_q != 2'd3)
		else $error("beat counter out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		beat_q != BEAT_WREN |-> !queue_empty && head.op == JOB_STEP)
		else $error("beat counter running without a step job");
	assert property (@(posedge clk) disable iff (!arst_n)
		queue_pop |=> out_valid_q && last_q)
		else $error("job released without its last word");

endmodule
`default_nettype wire

// ===== design/spi_nor_erase_sequencer_top.sv =====
// top level of the spi nor erase sequencer
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tuser kind, tdata address, length, status
// m_axis    out  m_axis_tvalid/tready       tdata word, address, outcome; tuser; tlast
// cfg       in   cfg_valid/cfg_ready        cfg_data poll limit
//
// the front takes one item per cycle while the job queue has room
// a start or ready status item that plans a step yields three words, a busy status
// item one word, an end of run one word; the back sends one word per unstalled cycle
// arst_n clears the erase state, the queue and the output register; poll limit to 300000
// a stalled m_axis holds its word; the queue lets the front keep accepting meanwhile
`timescale 1ns / 1ps
`default_nettype none
module spi_nor_erase_sequencer_top
	import nor_erase_pkg::*;
#(
	parameter int SUBSECTOR_MASK_BITS = SUBSECTOR_MASK_BITS_DEFAULT,
	parameter int SECTOR_MASK_BITS    = SECTOR_MASK_BITS_DEFAULT,
	parameter int JOB_FIFO_DEPTH      = JOB_FIFO_DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// start_address [31:0], erase_length [63:32], status_byte [71:64]
	input  wire logic [71:0] s_axis_tdata,
	// kind [0]
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// command_word [31:0], flash_address [63:32], outcome [65:64], zero [71:66]
	output logic      [71:0] m_axis_tdata,
	// has_address [0]
	output logic             m_axis_tuser,
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [18:0] cfg_data
);

	localparam int JOB_W = $bits(job_t);

	job_push_t        queue_in;
	logic             queue_full;
	logic             queue_empty;
	logic             queue_pop;
	logic [JOB_W-1:0] queue_rd;
	job_t             head;
	logic [31:0]      out_word;
	logic [31:0]      out_address;
	logic [1:0]       out_outcome;

	assign cfg_ready    = 1'b1;
	assign head         = job_t'(queue_rd);
	assign m_axis_tdata = {6'd0, out_outcome, out_address, out_word};

	// front: item intake and planning
	nor_erase_front #(
		.SUBSECTOR_MASK_BITS(SUBSECTOR_MASK_BITS),
		.SECTOR_MASK_BITS   (SECTOR_MASK_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_address(s_axis_tdata[31:0]),
		.in_length (s_axis_tdata[63:32]),
		.in_status (s_axis_tdata[71:64]),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_value (cfg_data),
		.queue_full(queue_full),
		.queue_in  (queue_in)
	);

	// job queue
	nor_erase_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(JOB_FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (queue_in.push),
		.wr_data(queue_in.job),
		.pop    (queue_pop),
		.rd_data(queue_rd),
		.full   (queue_full),
		.empty  (queue_empty)
	);

	// back: command word emission
	nor_erase_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.queue_empty    (queue_empty),
		.queue_pop      (queue_pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_word       (out_word),
		.out_address    (out_address),
		.out_has_address(m_axis_tuser),
		.out_outcome    (out_outcome),
		.out_last       (m_axis_tlast)
	);

endmodule
`default_nettype wire
